// ----- rtl/pfb_pkg.sv -----
`default_nettype none

package pfb_pkg;

  // Screen size defaults
  localparam int WIDTH_DEF  = 128;
  localparam int HEIGHT_DEF = 64;

  // Channel widths
  localparam int COORD_W     = 10;
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;

  // Command codes carried on in_tuser
  typedef enum logic [2:0] {
    MODE_CLEAR   = 3'd0,
    MODE_PIXEL   = 3'd1,
    MODE_OUTLINE = 3'd2,
    MODE_FILL    = 3'd3,
    MODE_READ    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_DRAW,
    S_READ,
    S_READ_DATA
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted command
    logic clear_step;  // write zero at the sweep address and advance
    logic draw_step;   // read one byte of the box and advance
    logic rd_issue;    // read the byte asked for by a read command
    logic rd_load;     // move the read byte into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic draw_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/pfb_ctrl.sv -----
`default_nettype none

module pfb_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [pfb_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire pfb_pkg::ctrl_sts_t           sts,
  output pfb_pkg::ctrl_cmd_t                cmd
);
  import pfb_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r) inside
      S_INIT, S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (mode_t'(in_tuser)) inside
            MODE_CLEAR: state_nxt = S_CLEAR;
            MODE_PIXEL, MODE_OUTLINE, MODE_FILL: state_nxt = S_DRAW;
            MODE_READ: state_nxt = S_READ;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DRAW: begin
        cmd.draw_step = 1'b1;
        if (sts.draw_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_READ_DATA;
        end
      end
      S_READ_DATA: begin
        cmd.rd_load = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/pfb_datapath.sv -----
`default_nettype none

module pfb_datapath #(
  parameter int WIDTH_PIXELS  = pfb_pkg::WIDTH_DEF,
  parameter int HEIGHT_PIXELS = pfb_pkg::HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [pfb_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [pfb_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire pfb_pkg::ctrl_cmd_t             cmd,
  output pfb_pkg::ctrl_sts_t                  sts,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [pfb_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import pfb_pkg::*;

  localparam int PAGE_COUNT = (HEIGHT_PIXELS + 7) / 8;
  localparam int DEPTH      = WIDTH_PIXELS * PAGE_COUNT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COL_W      = $clog2(WIDTH_PIXELS);
  localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ROW_W      = PAGE_W + 3;

  localparam logic signed [COORD_W-1:0] X_MAX = COORD_W'(WIDTH_PIXELS - 1);
  localparam logic signed [COORD_W-1:0] Y_MAX = COORD_W'(HEIGHT_PIXELS - 1);
  localparam logic signed [COORD_W:0]   H_LIM = (COORD_W + 1)'(HEIGHT_PIXELS);

  function automatic logic [COORD_W-1:0] clamp_coord(
    input logic signed [COORD_W-1:0] v,
    input logic signed [COORD_W-1:0] hi
  );
    logic [COORD_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Input fields
  logic signed [COORD_W-1:0] f_x_start, f_y_start, f_x_end, f_y_end;
  logic                      f_pixel_on;
  logic [2:0]                f_read_page;
  logic [6:0]                f_read_column;
  mode_t                     f_mode;

  assign f_x_start     = in_tdata[9:0];
  assign f_y_start     = in_tdata[19:10];
  assign f_x_end       = in_tdata[29:20];
  assign f_y_end       = in_tdata[39:30];
  assign f_pixel_on    = in_tdata[40];
  assign f_read_page   = in_tdata[43:41];
  assign f_read_column = in_tdata[50:44];
  assign f_mode        = mode_t'(in_tuser);

  // Command registers
  logic signed [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic                      on_r, outline_r;
  logic [COL_W-1:0]          col_r, col_lo_r, col_hi_r;
  logic [PAGE_W-1:0]         page_r, page_hi_r;
  logic [ADDR_W-1:0]         row_base_r;
  logic [ADDR_W-1:0]         rd_addr_r;
  logic                      rd_ok_r;

  // Clamped box of the command being accepted
  logic signed [COORD_W-1:0] x1_sel, y1_sel;
  logic [COORD_W-1:0]        cx0, cx1, cy0, cy1;
  logic [COL_W-1:0]          col_lo_nxt, col_hi_nxt;
  logic [ROW_W-1:0]          row_lo_nxt, row_hi_nxt;
  logic [PAGE_W-1:0]         page_lo_nxt;
  logic [ADDR_W-1:0]         rd_lin;

  always_comb begin
    // a single pixel is a one by one fill
    x1_sel = (f_mode == MODE_PIXEL) ? f_x_start : f_x_end;
    y1_sel = (f_mode == MODE_PIXEL) ? f_y_start : f_y_end;
    cx0 = clamp_coord(f_x_start, X_MAX);
    cx1 = clamp_coord(x1_sel, X_MAX);
    cy0 = clamp_coord(f_y_start, Y_MAX);
    cy1 = clamp_coord(y1_sel, Y_MAX);
    col_lo_nxt  = (cx0 < cx1) ? cx0[COL_W-1:0] : cx1[COL_W-1:0];
    col_hi_nxt  = (cx0 < cx1) ? cx1[COL_W-1:0] : cx0[COL_W-1:0];
    row_lo_nxt  = (cy0 < cy1) ? cy0[ROW_W-1:0] : cy1[ROW_W-1:0];
    row_hi_nxt  = (cy0 < cy1) ? cy1[ROW_W-1:0] : cy0[ROW_W-1:0];
    page_lo_nxt = row_lo_nxt[ROW_W-1:3];
    rd_lin      = ADDR_W'(f_read_page * WIDTH_PIXELS) + ADDR_W'(f_read_column);
  end

  // Latch the command
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r       <= f_x_start;
      y0_r       <= f_y_start;
      x1_r       <= x1_sel;
      y1_r       <= y1_sel;
      on_r       <= f_pixel_on;
      outline_r  <= (f_mode == MODE_OUTLINE);
      col_lo_r   <= col_lo_nxt;
      col_hi_r   <= col_hi_nxt;
      col_r      <= col_lo_nxt;
      page_r     <= page_lo_nxt;
      page_hi_r  <= row_hi_nxt[ROW_W-1:3];
      row_base_r <= ADDR_W'(page_lo_nxt * WIDTH_PIXELS);
      rd_addr_r  <= rd_lin;
      rd_ok_r    <= (int'(f_read_page) < PAGE_COUNT) && (int'(f_read_column) < WIDTH_PIXELS);
    end else if (cmd.draw_step) begin
      // advance through the box, column first
      if (col_r == col_hi_r) begin
        col_r      <= col_lo_r;
        page_r     <= page_r + 1'b1;
        row_base_r <= row_base_r + ADDR_W'(WIDTH_PIXELS);
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // Pixel mask of the current byte
  logic [ADDR_W-1:0]       draw_addr;
  logic [7:0]              mask_nxt;
  logic signed [COORD_W:0] cs, x0e, x1e, y0e, y1e;
  logic                    in_x, on_v;

  always_comb begin
    draw_addr = row_base_r + ADDR_W'(col_r);
    cs   = $signed({{(COORD_W + 1 - COL_W){1'b0}}, col_r});
    x0e  = {x0_r[COORD_W-1], x0_r};
    x1e  = {x1_r[COORD_W-1], x1_r};
    y0e  = {y0_r[COORD_W-1], y0_r};
    y1e  = {y1_r[COORD_W-1], y1_r};
    in_x = (x0e <= cs) && (cs <= x1e);
    on_v = (cs == x0e) || (cs == x1e);
  end

  for (genvar b = 0; b < 8; b++) begin : g_lane
    logic signed [COORD_W:0] rs;
    logic                    in_y, on_h;
    assign rs   = $signed({{(COORD_W + 1 - ROW_W){1'b0}}, page_r, 3'(b)});
    assign in_y = (y0e <= rs) && (rs <= y1e);
    assign on_h = (rs == y0e) || (rs == y1e);
    assign mask_nxt[b] = (rs < H_LIM) &&
                         (outline_r ? ((on_h && in_x) || (on_v && in_y)) : (in_x && in_y));
  end

  // Write-back stage of the read-modify-write
  logic              wr_pend_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [7:0]        mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= cmd.draw_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_step) begin
      wr_addr_r <= draw_addr;
      mask_r    <= mask_nxt;
    end
  end

  // Clearing sweep address
  logic [ADDR_W-1:0] sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.clear_step) begin
      sweep_r <= sts.sweep_last ? '0 : sweep_r + 1'b1;
    end
  end

  // Frame store
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  always_comb begin
    mem_we    = cmd.clear_step || wr_pend_r;
    mem_waddr = cmd.clear_step ? sweep_r : wr_addr_r;
    mem_wdata = cmd.clear_step ? 8'h00 : (on_r ? (rdata_r | mask_r) : (rdata_r & ~mask_r));
    mem_re    = cmd.draw_step || cmd.rd_issue;
    mem_raddr = cmd.draw_step ? draw_addr : rd_addr_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Output register
  logic       out_valid_r;
  logic [7:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.rd_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      out_data_r <= rd_ok_r ? rdata_r : 8'h00;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status
  always_comb begin
    sts.sweep_last = (sweep_r == ADDR_W'(DEPTH - 1));
    sts.draw_last  = (col_r == col_hi_r) && (page_r == page_hi_r);
    sts.out_busy   = out_valid_r;
  end

endmodule

`default_nettype wire

// ----- rtl/page_framebuffer_draw_engine.sv -----
// Monochrome page-layout framebuffer with drawing commands.
//
// Input channel (in_*): one command per beat. in_tuser carries the mode
// (clear, pixel, outline, fill, read); in_tdata carries coordinates, the
// pixel value and the read page and column. in_tready is high only while
// the engine is idle, so one command is worked on at a time.
// Output channel (out_*): one beat with the byte for each read command.
//
// Work per command, from acceptance until in_tready returns:
//   clear: all PAGES*WIDTH_PIXELS store bytes, one store byte written per cycle.
//   pixel, outline, fill: each byte of the clamped bounding box (columns
//     times pages), one byte read and written back per cycle.
//   read: the byte is fetched in S_READ once the output register is free,
//     then loaded into it in S_READ_DATA as out_tvalid rises.
// Reset: the store is swept to zero, one byte per cycle, over all
//   PAGES*WIDTH_PIXELS bytes; in_tready stays low.
// A stalled receiver leaves the read byte held in the output register;
// drawing commands are still taken, and a further read waits for it.
`default_nettype none

module page_framebuffer_draw_engine #(
  parameter int WIDTH_PIXELS  = pfb_pkg::WIDTH_DEF,
  parameter int HEIGHT_PIXELS = pfb_pkg::HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // x_start[9:0], y_start[19:10], x_end[29:20], y_end[39:30], pixel_on[40],
  // read_page[43:41], read_column[50:44], zero fill [55:51]
  input  wire logic [pfb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[2:0]
  input  wire logic [pfb_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // read_byte[7:0]
  output logic [pfb_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import pfb_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  pfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfb_datapath #(
    .WIDTH_PIXELS  (WIDTH_PIXELS),
    .HEIGHT_PIXELS (HEIGHT_PIXELS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- rtl/pfb_checker.sv -----
`default_nettype none

module pfb_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [pfb_pkg::IN_TUSER_W-1:0]  in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [pfb_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pfb_pkg::*;

  logic in_beat;
  logic known_mode;

  assign in_beat    = in_tvalid && in_tready;
  assign known_mode = (in_tuser == MODE_CLEAR) || (in_tuser == MODE_PIXEL) ||
                      (in_tuser == MODE_OUTLINE) || (in_tuser == MODE_FILL) ||
                      (in_tuser == MODE_READ);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat dropped or changed");

  // Clearing pass keeps the input closed right after reset
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during reset clearing pass");

  // Any real command closes the input in the cycle after its beat
  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && known_mode |=> !in_tready)
    else $error("input ready straight after a command beat");

  // A read with a free output offers its byte after the S_READ and S_READ_DATA states
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_tuser == MODE_READ) && !out_tvalid |-> ##3 out_tvalid)
    else $error("read result late");

endmodule

bind page_framebuffer_draw_engine pfb_checker u_pfb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import pfb_pkg::*;

  localparam int SCREEN_W    = WIDTH_DEF;
  localparam int SCREEN_H    = HEIGHT_DEF;
  localparam int PAGE_COUNT  = (SCREEN_H + 7) / 8;
  localparam int STORE_BYTES = SCREEN_W * PAGE_COUNT;

  // Codes outside the command set: the engine must ignore them
  localparam logic [2:0] MODE_RSVD_5 = 3'd5;
  localparam logic [2:0] MODE_RSVD_6 = 3'd6;
  localparam logic [2:0] MODE_RSVD_7 = 3'd7;

  localparam int PHASE_COUNT   = 4;
  localparam int ITEMS_PER_PH  = 138;
  // Worst case: every command a full sweep, plus gaps and stalls, then margin
  localparam int unsigned CYCLE_LIMIT = 2_500_000;
  localparam int TAIL_CYCLES   = 1100;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [9:0] x0;
    logic signed [9:0] y0;
    logic signed [9:0] x1;
    logic signed [9:0] y1;
    logic              on;
    logic [2:0]        page;
    logic [6:0]        col;
  } draw_cmd_t;

  typedef struct packed {
    draw_cmd_t  cmd;
    logic       typed;
    logic [7:0] typed_byte;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predictor state and the bytes still owed by the engine
  logic [7:0] shadow_frame [STORE_BYTES];
  logic [7:0] owed_bytes [$];
  dir_row_t   dir_rows [$];

  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          n_errors = 0;
  int          n_checked = 0;
  int          n_reads = 0;
  int          n_draws = 0;
  int          n_clears = 0;
  int          n_ignored = 0;
  int          focus_x = 0;
  int          focus_y = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  got_expected;

  int src_pct_tab  [PHASE_COUNT] = '{0, 55, 0, 16};
  int sink_pct_tab [PHASE_COUNT] = '{0, 0, 55, 16};

  page_framebuffer_draw_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Read-back side: compare each beat with the oldest owed byte, then pick stall
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_bytes.size() == 0) begin
        $error("read_byte: beat with nothing owed, actual %02h", out_tdata);
        n_errors++;
      end else begin
        got_expected = owed_bytes.pop_front();
        n_checked++;
        if (out_tdata !== got_expected) begin
          $error("read_byte: expected %02h, actual %02h", got_expected, out_tdata);
          n_errors++;
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Set or clear one pixel, skipping anything off screen
  function automatic void plot(int x, int y, logic on);
    int idx;
    if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H) return;
    idx = (y / 8) * SCREEN_W + x;
    shadow_frame[idx][y % 8] = on;
  endfunction

  // Apply one command to the shadow frame; a read hands back the byte it sees
  function automatic void apply_draw_cmd(draw_cmd_t c, output logic has_byte,
                                         output logic [7:0] rd_byte);
    int x0, y0, x1, y1, xa, xb, ya, yb;
    x0 = c.x0;
    y0 = c.y0;
    x1 = c.x1;
    y1 = c.y1;
    xa = (x0 < 0) ? 0 : x0;
    xb = (x1 > SCREEN_W - 1) ? SCREEN_W - 1 : x1;
    ya = (y0 < 0) ? 0 : y0;
    yb = (y1 > SCREEN_H - 1) ? SCREEN_H - 1 : y1;
    has_byte = 1'b0;
    rd_byte = 8'h00;
    case (c.mode)
      MODE_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      end
      MODE_PIXEL: begin
        plot(x0, y0, c.on);
      end
      MODE_OUTLINE: begin
        for (int x = xa; x <= xb; x++) begin
          plot(x, y0, c.on);
          plot(x, y1, c.on);
        end
        for (int y = ya; y <= yb; y++) begin
          plot(x0, y, c.on);
          plot(x1, y, c.on);
        end
      end
      MODE_FILL: begin
        for (int y = ya; y <= yb; y++)
          for (int x = xa; x <= xb; x++)
            plot(x, y, c.on);
      end
      MODE_READ: begin
        has_byte = 1'b1;
        if (int'(c.page) < PAGE_COUNT && int'(c.col) < SCREEN_W)
          rd_byte = shadow_frame[int'(c.page) * SCREEN_W + int'(c.col)];
      end
      default: ;
    endcase
  endfunction

  // Offer one command, hold it until taken, then predict its effect
  task automatic send_cmd(draw_cmd_t c, logic typed, logic [7:0] typed_byte);
    logic       has_byte;
    logic [7:0] rd_byte;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, c.col, c.page, c.on, c.y1, c.x1, c.y0, c.x0};
    in_tuser  <= c.mode;
    do @(posedge clk); while (!in_tready);
    apply_draw_cmd(c, has_byte, rd_byte);
    if (has_byte) owed_bytes.push_back(typed ? typed_byte : rd_byte);
    case (c.mode) inside
      MODE_READ:                          n_reads++;
      MODE_PIXEL, MODE_OUTLINE, MODE_FILL: n_draws++;
      MODE_CLEAR:                         n_clears++;
      default:                            n_ignored++;
    endcase
  endtask

  // Drop valid and hold off until every owed byte has come back
  task automatic drain_reads();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (owed_bytes.size() != 0);
  endtask

  function automatic void add_row(logic [2:0] mode, int x0, int y0, int x1, int y1,
                                  logic on, int page, int col,
                                  logic typed = 1'b0, logic [7:0] typed_byte = 8'h00);
    dir_row_t r;
    r.cmd.mode = mode;
    r.cmd.x0   = 10'(x0);
    r.cmd.y0   = 10'(y0);
    r.cmd.x1   = 10'(x1);
    r.cmd.y1   = 10'(y1);
    r.cmd.on   = on;
    r.cmd.page = 3'(page);
    r.cmd.col  = 7'(col);
    r.typed      = typed;
    r.typed_byte = typed_byte;
    dir_rows.push_back(r);
  endfunction

  // Mostly small boxes anywhere on or just past the screen, now and then any coordinates
  function automatic void shape_box(inout draw_cmd_t c);
    int xs, ys, w, h;
    logic signed [9:0] t;
    if ($urandom_range(0, 19) == 0) return;
    xs = int'($urandom_range(0, 143)) - 8;
    ys = int'($urandom_range(0, 79)) - 8;
    w  = $urandom_range(0, 14);
    h  = $urandom_range(0, 14);
    c.x0 = 10'(xs);
    c.x1 = 10'(xs + w);
    c.y0 = 10'(ys);
    c.y1 = 10'(ys + h);
    // an empty range now and then
    if ($urandom_range(0, 9) == 0) begin
      t = c.x0; c.x0 = c.x1; c.x1 = t;
    end
    if ($urandom_range(0, 9) == 0) begin
      t = c.y0; c.y0 = c.y1; c.y1 = t;
    end
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int r;
    c.x0   = 10'($urandom);
    c.y0   = 10'($urandom);
    c.x1   = 10'($urandom);
    c.y1   = 10'($urandom);
    c.on   = 1'($urandom);
    c.page = 3'($urandom);
    c.col  = 7'($urandom);
    r = $urandom_range(0, 99);
    if (r < 32) begin
      c.mode = MODE_READ;
      // aim most reads where drawing just happened
      if ($urandom_range(0, 9) < 7) begin
        c.col  = 7'(focus_x + int'($urandom_range(0, 15)) - 4);
        c.page = 3'(focus_y / 8 + int'($urandom_range(0, 1)));
      end
    end else if (r < 95) begin
      if (r < 57) begin
        c.mode = MODE_PIXEL;
        if ($urandom_range(0, 9) != 0) begin
          c.x0 = 10'(int'($urandom_range(0, 135)) - 4);
          c.y0 = 10'(int'($urandom_range(0, 71)) - 4);
        end
      end else if (r < 74) begin
        c.mode = MODE_OUTLINE;
        shape_box(c);
      end else if (r < 92) begin
        c.mode = MODE_FILL;
        shape_box(c);
      end else begin
        c.mode = MODE_CLEAR;
      end
      focus_x = (c.x0 < 0) ? 0 : (c.x0 > SCREEN_W - 1) ? SCREEN_W - 1 : int'(c.x0);
      focus_y = (c.y0 < 0) ? 0 : (c.y0 > SCREEN_H - 1) ? SCREEN_H - 1 : int'(c.y0);
    end else begin
      c.mode = 3'($urandom_range(MODE_RSVD_5, MODE_RSVD_7));
    end
    return c;
  endfunction

  initial begin
    draw_cmd_t c;
    int        taken;

    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;

    // Directed table: empty store, corners, off-screen pixels, empty ranges,
    // full-screen fill, ignored codes and clear
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 0, 0,   1'b1, 8'h00);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 7, 127, 1'b1, 8'h00);
    add_row(MODE_PIXEL,    0,    0,    0,   0,   1'b1, 0, 0);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 0, 0,   1'b1, 8'h01);
    add_row(MODE_PIXEL,    127,  63,   0,   0,   1'b1, 0, 0);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 7, 127, 1'b1, 8'h80);
    add_row(MODE_PIXEL,    -1,   5,    0,   0,   1'b1, 0, 0);
    add_row(MODE_PIXEL,    128,  63,   0,   0,   1'b1, 0, 0);
    add_row(MODE_PIXEL,    0,    -512, 0,   0,   1'b1, 0, 0);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 7, 0);
    add_row(MODE_OUTLINE,  -512, -512, 511, 511, 1'b1, 0, 0);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 0, 5);
    add_row(MODE_OUTLINE,  2,    3,    20,  12,  1'b1, 0, 0);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 0, 2);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 1, 20);
    add_row(MODE_OUTLINE,  0,    20,   127, 10,  1'b1, 0, 0);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 1, 60);
    add_row(MODE_FILL,     -512, -512, 511, 511, 1'b1, 0, 0);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 3, 64,  1'b1, 8'hFF);
    add_row(MODE_FILL,     8,    8,    15,  15,  1'b0, 0, 0);
    add_row(MODE_FILL,     10,   0,    5,   63,  1'b0, 0, 0);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 1, 8,   1'b1, 8'h00);
    add_row(MODE_RSVD_5,   0,    0,    127, 63,  1'b0, 3, 64);
    add_row(MODE_RSVD_6,   -512, -512, 511, 511, 1'b0, 7, 127);
    add_row(MODE_RSVD_7,   511,  511,  -512, -512, 1'b1, 0, 0);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 1, 16,  1'b1, 8'hFF);
    add_row(MODE_CLEAR,    0,    0,    0,   0,   1'b0, 0, 0);
    add_row(MODE_READ,     0,    0,    0,   0,   1'b0, 4, 100, 1'b1, 8'h00);

    // Hold reset, then release; the engine sweeps its store before taking beats
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].typed_byte);
    drain_reads();

    // Random commands under each idling profile, draining between profiles
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      src_idle_pct = src_pct_tab[ph];
      sink_stall_pct <= sink_pct_tab[ph];
      taken = 0;
      while (taken < ITEMS_PER_PH) begin
        c = random_cmd();
        send_cmd(c, 1'b0, 8'h00);
        taken++;
      end
      drain_reads();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d reads, %0d pixel/outline/fill draws, %0d clears, %0d ignored codes",
             n_reads, n_draws, n_clears, n_ignored);
    $display("over four handshake profiles; %0d read-back bytes compared", n_checked);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
